### rtl/core/neuron_forward_backprop_momentum_top_defines.svh
// ----------------------------------------------------------------------------
// Neuron assertion macros
// Shared assertion forms for the neuron block's checkers.
// ----------------------------------------------------------------------------
`ifndef NEURON_FORWARD_BACKPROP_MOMENTUM_TOP_DEFINES_SVH
`define NEURON_FORWARD_BACKPROP_MOMENTUM_TOP_DEFINES_SVH

// Assertion that is checked at every edge, reset included.
`define NFBM_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("nfbm assertion failed");

// Assertion that is switched off while reset is asserted.
`define NFBM_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nfbm assertion failed");

`endif

### rtl/core/nfbm_pkg.sv
// ----------------------------------------------------------------------------
// Neuron package
// Types, codes, reset values, saturation helpers and activation entries.
// ----------------------------------------------------------------------------
package nfbm_pkg;

    localparam logic [2:0] FUNC_FORWARD  = 3'd0;
    localparam logic [2:0] FUNC_OUT_GRAD = 3'd1;
    localparam logic [2:0] FUNC_HID_GRAD = 3'd2;
    localparam logic [2:0] FUNC_UPDATE   = 3'd3;
    localparam logic [2:0] FUNC_LOAD     = 3'd4;

    localparam logic [1:0] KIND_OUTPUT = 2'd0;
    localparam logic [1:0] KIND_GRAD   = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_LOAD   = 2'd3;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_LEARN    = 2'd1;
    localparam logic [1:0] CFG_MOMENTUM = 2'd2;

    localparam logic [11:0] LEARN_RESET    = 12'd614;
    localparam logic [11:0] MOMENTUM_RESET = 12'd2048;
    localparam logic [63:0] EXP_M1_Q32     = 64'd1580030169;

    typedef struct packed {
        logic        mode;
        logic [11:0] eta;
        logic [11:0] alpha;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] value;
        logic signed [15:0] next_weight;
        logic               last;
        logic               in_range;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_ACC, ST_IDX, ST_TAB, ST_DER1, ST_DER2,
        ST_GRAD, ST_GSAT, ST_UPD1, ST_UPD2, ST_UPD3
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) r = 16'sh7FFF;
        else if (v < -64'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Unsigned quotient by shift and subtract, used on elaboration constants only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q32(input logic [31:0] t);
        logic [31:0] k;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        k = t >> 12;
        f = {32'd0, t & 32'h0000_0FFF} << 20;
        term = 64'd1 << 32;
        pos = term;
        neg = 64'd0;
        for (int n = 1; n < 16; n++) begin
            term = udiv64((term * f) >> 32, 64'(n));
            if ((n & 1) != 0) neg = neg + term;
            else pos = pos + term;
        end
        r = pos - neg;
        for (int m = 0; m < 32; m++) begin
            if (32'(m) < k && r != 64'd0) r = (r * EXP_M1_Q32) >> 32;
        end
        return r;
    endfunction

    // Activation entry for a table of the given depth, evaluated at elaboration.
    function automatic logic signed [15:0] act_entry(input int i, input int depth,
                                                     input logic sig);
        int          xi;
        logic [31:0] a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] r;
        xi = int'(udiv64(64'((2 * i + 1) * 32768), 64'(depth))) - 32768;
        a = (xi < 0) ? 32'(-xi) : 32'(xi);
        if (sig) begin
            e = exp_neg_q32(a);
            den = (64'd1 << 32) + e;
            num = (xi < 0) ? e : (64'd1 << 32);
            r = udiv64(num * 64'd4096 + (den >> 1), den);
            return r[15:0];
        end
        e = exp_neg_q32(2 * a);
        den = (64'd1 << 32) + e;
        r = udiv64(((64'd1 << 32) - e) * 64'd4096 + (den >> 1), den);
        return (xi < 0) ? -r[15:0] : r[15:0];
    endfunction

endpackage

### rtl/core/nfbm_ram.sv
// ----------------------------------------------------------------------------
// Neuron generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nfbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/nfbm_front.sv
// ----------------------------------------------------------------------------
// Neuron front end
// Accepts items, tracks the element index and classifies range.
// ----------------------------------------------------------------------------
module nfbm_front #(
    parameter int MAX_INPUTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2:0]                    i_func,
    input  logic signed [15:0]            i_value,
    input  logic signed [15:0]            i_next_weight,
    input  logic                          i_last,
    input  logic                          i_full,
    output logic                          o_push,
    output nfbm_pkg::t_item               o_item,
    output logic [$clog2(MAX_INPUTS)-1:0] o_idx,
    output logic                          o_busy
);

    localparam int IW = $clog2(MAX_INPUTS + 1);
    localparam int AW = $clog2(MAX_INPUTS);

    logic [IW-1:0] r_index;
    logic [IW-1:0] n_index;
    logic          in_range;

    assign in_range = r_index < IW'(MAX_INPUTS);
    assign o_busy   = i_full;
    assign o_push   = i_start && !i_full;

    always_comb begin
        o_item.func        = i_func;
        o_item.value       = i_value;
        o_item.next_weight = i_next_weight;
        o_item.last        = i_last;
        o_item.in_range    = in_range;
        o_idx              = in_range ? r_index[AW-1:0] : '0;
    end

    always_comb begin
        n_index = r_index;
        if (i_last) begin
            n_index = '0;
        end else if (in_range && i_func != nfbm_pkg::FUNC_OUT_GRAD
                     && i_func <= nfbm_pkg::FUNC_LOAD) begin
            n_index = r_index + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (o_push) begin
            r_index <= n_index;
        end
    end

endmodule

### rtl/core/nfbm_queue.sv
// ----------------------------------------------------------------------------
// Neuron item queue
// Two-entry queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module nfbm_queue #(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            if (i_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/core/nfbm_back.sv
// ----------------------------------------------------------------------------
// Neuron sequencer
// Carries out queued items on one shared multiplier and the weight and change stores.
// ----------------------------------------------------------------------------
module nfbm_back #(
    parameter int MAX_INPUTS      = 64,
    parameter int ACT_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nfbm_pkg::t_cfg                i_cfg,
    input  logic                          i_empty,
    input  nfbm_pkg::t_item               i_item,
    input  logic [$clog2(MAX_INPUTS)-1:0] i_idx,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic signed [15:0]            o_value,
    output logic [1:0]                    o_kind
);

    localparam int AW = $clog2(MAX_INPUTS);
    localparam int TW = $clog2(ACT_TABLE_DEPTH);

    logic signed [15:0] tanh_tab [ACT_TABLE_DEPTH];
    logic signed [15:0] sig_tab  [ACT_TABLE_DEPTH];

    for (genvar g = 0; g < ACT_TABLE_DEPTH; g++) begin : g_tab
        localparam logic signed [15:0] TanhV = nfbm_pkg::act_entry(g, ACT_TABLE_DEPTH, 1'b0);
        localparam logic signed [15:0] SigV  = nfbm_pkg::act_entry(g, ACT_TABLE_DEPTH, 1'b1);
        assign tanh_tab[g] = TanhV;
        assign sig_tab[g]  = SigV;
    end

    nfbm_pkg::t_state   r_state;
    nfbm_pkg::t_state   n_state;
    nfbm_pkg::t_item    r_item;
    logic [AW-1:0]      r_idx;
    logic               r_cv;
    logic [MAX_INPUTS-1:0] r_cvalid;
    logic signed [15:0] r_w;
    logic signed [15:0] r_cold;
    logic signed [31:0] r_acc;
    logic signed [15:0] r_out;
    logic signed [15:0] r_grad;
    logic signed [20:0] r_der;
    logic signed [52:0] r_prod;
    logic signed [52:0] r_tmp;
    logic [TW-1:0]      r_ti;
    logic               r_valid;
    logic signed [15:0] r_value;
    logic [1:0]         r_kind;

    logic signed [15:0] w_rdata;
    logic signed [15:0] c_rdata;
    logic               w_we;
    logic               c_we;
    logic signed [15:0] w_wdata;

    logic signed [31:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [52:0] mul_p;

    logic               emit;
    logic signed [15:0] emit_value;
    logic [1:0]         emit_kind;

    logic signed [33:0] acc_sum;
    logic signed [15:0] x_sat;
    logic [31:0]        ti_wide;
    logic signed [20:0] der_shift;
    logic signed [20:0] der_next;
    logic signed [15:0] g_next;
    logic signed [55:0] t_sum;
    logic signed [15:0] c_next;
    logic signed [15:0] w_next;
    logic signed [15:0] y_tab;
    logic signed [16:0] one_minus_y;
    logic signed [16:0] delta;

    nfbm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_weight_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_idx),
        .i_wdata(w_wdata),
        .i_raddr(i_idx),
        .o_rdata(w_rdata)
    );

    nfbm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_change_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(r_idx),
        .i_wdata(c_next),
        .i_raddr(i_idx),
        .o_rdata(c_rdata)
    );

    assign mul_p       = 53'(mul_a) * 53'(mul_b);
    assign acc_sum     = 34'(r_acc) + 34'($signed(r_prod[31:0]));
    assign x_sat       = nfbm_pkg::sat16(64'(r_acc >>> 12));
    assign ti_wide     = (32'({~x_sat[15], x_sat[14:0]}) * 32'(ACT_TABLE_DEPTH)) >> 16;
    assign der_shift   = 21'(r_prod >>> 12);
    assign der_next    = i_cfg.mode ? der_shift : 21'sd4096 - der_shift;
    assign t_sum       = 56'(r_tmp) + (56'(r_prod) <<< 12);
    assign c_next      = nfbm_pkg::sat16(64'(t_sum >>> 24));
    assign w_next      = nfbm_pkg::sat16(64'(17'(r_w) + 17'(c_next)));
    assign y_tab       = i_cfg.mode ? sig_tab[r_ti] : tanh_tab[r_ti];
    assign one_minus_y = 17'sd4096 - 17'(r_out);
    assign delta       = 17'(r_item.value) - 17'(r_out);

    always_comb begin
        if (r_item.func == nfbm_pkg::FUNC_HID_GRAD) begin
            g_next = nfbm_pkg::sat16(64'(r_prod >>> 24));
        end else begin
            g_next = nfbm_pkg::sat16(64'(r_prod >>> 12));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nfbm_pkg::ST_IDLE: begin
                if (!i_empty) n_state = nfbm_pkg::ST_FETCH;
            end
            nfbm_pkg::ST_FETCH: begin
                case (r_item.func)
                    nfbm_pkg::FUNC_FORWARD, nfbm_pkg::FUNC_HID_GRAD: n_state = nfbm_pkg::ST_ACC;
                    nfbm_pkg::FUNC_OUT_GRAD: n_state = nfbm_pkg::ST_DER1;
                    nfbm_pkg::FUNC_UPDATE: n_state = nfbm_pkg::ST_UPD1;
                    default: n_state = nfbm_pkg::ST_IDLE;
                endcase
            end
            nfbm_pkg::ST_ACC: begin
                if (!r_item.last) n_state = nfbm_pkg::ST_IDLE;
                else if (r_item.func == nfbm_pkg::FUNC_FORWARD) n_state = nfbm_pkg::ST_IDX;
                else n_state = nfbm_pkg::ST_DER1;
            end
            nfbm_pkg::ST_IDX:  n_state = nfbm_pkg::ST_TAB;
            nfbm_pkg::ST_TAB:  n_state = nfbm_pkg::ST_IDLE;
            nfbm_pkg::ST_DER1: n_state = nfbm_pkg::ST_DER2;
            nfbm_pkg::ST_DER2: n_state = nfbm_pkg::ST_GRAD;
            nfbm_pkg::ST_GRAD: n_state = nfbm_pkg::ST_GSAT;
            nfbm_pkg::ST_GSAT: n_state = nfbm_pkg::ST_IDLE;
            nfbm_pkg::ST_UPD1: n_state = nfbm_pkg::ST_UPD2;
            nfbm_pkg::ST_UPD2: n_state = nfbm_pkg::ST_UPD3;
            nfbm_pkg::ST_UPD3: n_state = nfbm_pkg::ST_IDLE;
            default: n_state = nfbm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        w_we       = 1'b0;
        c_we       = 1'b0;
        w_wdata    = w_next;
        emit       = 1'b0;
        emit_value = '0;
        emit_kind  = nfbm_pkg::KIND_OUTPUT;
        case (r_state)
            nfbm_pkg::ST_IDLE: begin
                o_pop = !i_empty;
            end
            nfbm_pkg::ST_FETCH: begin
                case (r_item.func)
                    nfbm_pkg::FUNC_FORWARD: begin
                        mul_a = 32'(r_item.value);
                        mul_b = r_item.in_range ? 21'(w_rdata) : '0;
                    end
                    nfbm_pkg::FUNC_HID_GRAD: begin
                        mul_a = 32'(r_item.next_weight);
                        mul_b = 21'(r_item.value);
                    end
                    nfbm_pkg::FUNC_UPDATE: begin
                        mul_a = 32'($signed({1'b0, i_cfg.eta}));
                        mul_b = 21'(r_item.value);
                    end
                    nfbm_pkg::FUNC_LOAD: begin
                        w_we      = r_item.in_range;
                        w_wdata   = r_item.value;
                        emit      = r_item.last;
                        emit_kind = nfbm_pkg::KIND_LOAD;
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
            nfbm_pkg::ST_TAB: begin
                emit       = 1'b1;
                emit_value = y_tab;
                emit_kind  = nfbm_pkg::KIND_OUTPUT;
            end
            nfbm_pkg::ST_DER1: begin
                mul_a = 32'(r_out);
                mul_b = i_cfg.mode ? 21'(one_minus_y) : 21'(r_out);
            end
            nfbm_pkg::ST_GRAD: begin
                mul_a = (r_item.func == nfbm_pkg::FUNC_HID_GRAD) ? r_acc : 32'(delta);
                mul_b = r_der;
            end
            nfbm_pkg::ST_GSAT: begin
                emit       = 1'b1;
                emit_value = g_next;
                emit_kind  = nfbm_pkg::KIND_GRAD;
            end
            nfbm_pkg::ST_UPD1: begin
                mul_a = r_prod[31:0];
                mul_b = 21'(r_grad);
            end
            nfbm_pkg::ST_UPD2: begin
                mul_a = 32'($signed({1'b0, i_cfg.alpha}));
                mul_b = 21'(r_cold);
            end
            nfbm_pkg::ST_UPD3: begin
                w_we      = r_item.in_range;
                c_we      = r_item.in_range;
                emit      = r_item.last;
                emit_kind = nfbm_pkg::KIND_UPDATE;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nfbm_pkg::ST_IDLE;
            r_valid  <= 1'b0;
            r_acc    <= '0;
            r_out    <= '0;
            r_grad   <= '0;
            r_cvalid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= emit;
            if (r_state == nfbm_pkg::ST_ACC) r_acc <= nfbm_pkg::sat32(64'(acc_sum));
            if (r_state == nfbm_pkg::ST_TAB) begin
                r_out <= y_tab;
                r_acc <= '0;
            end
            if (r_state == nfbm_pkg::ST_GSAT) begin
                r_grad <= g_next;
                if (r_item.func == nfbm_pkg::FUNC_HID_GRAD) r_acc <= '0;
            end
            if (c_we) r_cvalid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_p;
        r_value <= emit_value;
        r_kind  <= emit_kind;
        if (o_pop) begin
            r_item <= i_item;
            r_idx  <= i_idx;
            r_cv   <= r_cvalid[i_idx];
        end
        if (r_state == nfbm_pkg::ST_FETCH) begin
            r_w    <= w_rdata;
            r_cold <= r_cv ? c_rdata : '0;
        end
        if (r_state == nfbm_pkg::ST_IDX) r_ti <= ti_wide[TW-1:0];
        if (r_state == nfbm_pkg::ST_DER2) r_der <= der_next;
        if (r_state == nfbm_pkg::ST_UPD2) r_tmp <= r_prod;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_kind  = r_kind;

endmodule

### rtl/core/neuron_forward_backprop_momentum_top.sv
// ----------------------------------------------------------------------------
// Backpropagation neuron with momentum
// Forward sums, gradients and momentum weight updates in Q4.12.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-item queue
// lies behind the port, so busy rises only when two items wait. Items are
// carried out one at a time by a sequencer around one shared multiplier, a
// weight store and a weight-change store, each with one write port and one
// read port with registered reads. Each result appears for one cycle with
// o_result_valid, one cycle after the sequencer finishes the item, and
// cannot be held off, so it must be captured when it appears.
module neuron_forward_backprop_momentum_top #(
    parameter int MAX_INPUTS      = 64,
    parameter int ACT_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_func,
    input  logic signed [15:0] i_value,
    input  logic signed [15:0] i_next_weight,
    input  logic               i_last,
    output logic               o_result_valid,
    output logic signed [15:0] o_result_value,
    output logic [1:0]         o_result_kind,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_INPUTS);
    localparam int QW = $bits(nfbm_pkg::t_item) + AW;

    nfbm_pkg::t_cfg  r_cfg;
    nfbm_pkg::t_item fe_item;
    nfbm_pkg::t_item q_item;
    logic [AW-1:0]   fe_idx;
    logic [AW-1:0]   q_idx;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic [QW-1:0]   q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= 1'b0;
            r_cfg.eta   <= nfbm_pkg::LEARN_RESET;
            r_cfg.alpha <= nfbm_pkg::MOMENTUM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nfbm_pkg::CFG_MODE:     r_cfg.mode  <= i_cfg_data[0];
                nfbm_pkg::CFG_LEARN:    r_cfg.eta   <= i_cfg_data;
                nfbm_pkg::CFG_MOMENTUM: r_cfg.alpha <= i_cfg_data;
                default:                r_cfg       <= r_cfg;
            endcase
        end
    end

    nfbm_front #(.MAX_INPUTS(MAX_INPUTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_next_weight(i_next_weight),
        .i_last       (i_last),
        .i_full       (full),
        .o_push       (push),
        .o_item       (fe_item),
        .o_idx        (fe_idx),
        .o_busy       (busy)
    );

    nfbm_queue #(.WIDTH(QW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({fe_item, fe_idx}),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_data (q_data)
    );

    assign q_item = q_data[QW-1:AW];
    assign q_idx  = q_data[AW-1:0];

    nfbm_back #(.MAX_INPUTS(MAX_INPUTS), .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_empty(empty),
        .i_item (q_item),
        .i_idx  (q_idx),
        .o_pop  (pop),
        .o_valid(o_result_valid),
        .o_value(o_result_value),
        .o_kind (o_result_kind)
    );

endmodule

### rtl/core/nfbm_checker.sv
// ----------------------------------------------------------------------------
// Neuron port checker
// Checks result strobes and acknowledges seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "neuron_forward_backprop_momentum_top_defines.svh"

module nfbm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_result_valid,
    input logic signed [15:0] o_result_value,
    input logic [1:0]         o_result_kind
);

    logic ack_kind;

    assign ack_kind = o_result_kind == nfbm_pkg::KIND_UPDATE
                   || o_result_kind == nfbm_pkg::KIND_LOAD;

    `NFBM_ASSERT(a_reset_quiet, i_clk, !i_rst_n |=> !o_result_valid && !busy)
    `NFBM_ASSERT_RST(a_strobe_gap, i_clk, i_rst_n, o_result_valid |=> !o_result_valid)
    `NFBM_ASSERT_RST(a_ack_zero, i_clk, i_rst_n, o_result_valid && ack_kind |-> !(|o_result_value))

endmodule

bind neuron_forward_backprop_momentum_top nfbm_checker u_nfbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_result_valid(o_result_valid),
    .o_result_value(o_result_value),
    .o_result_kind (o_result_kind)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Neuron block testbench
// Drives load, forward, gradient and momentum update runs through the command
// port under several register settings and compares every result with a
// fixed-point predictor of the neuron kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STORE_DEPTH = 64;
    localparam int ACT_DEPTH   = 256;
    localparam int WATCHDOG    = 4000;

    typedef struct {
        logic signed [15:0] value;
        logic [1:0]         kind;
    } t_neuron_result;

    class neuron_scoreboard;
        logic signed [15:0] tanh_lut[ACT_DEPTH];
        logic signed [15:0] sig_lut[ACT_DEPTH];
        logic               mode;
        logic [11:0]        eta;
        logic [11:0]        alpha;
        logic signed [15:0] weights[STORE_DEPTH];
        logic signed [15:0] changes[STORE_DEPTH];
        bit                 loaded[STORE_DEPTH];
        logic signed [31:0] acc;
        logic signed [15:0] out_val;
        logic signed [15:0] grad_val;
        int                 elem_idx;
        t_neuron_result     pending[$];
        int                 errors;

        function new();
            logic signed [31:0] xi;
            for (int i = 0; i < ACT_DEPTH; i++) begin
                xi = ((2 * i + 1) * 32768) / ACT_DEPTH - 32768;
                tanh_lut[i] = tanh_q12(xi);
                sig_lut[i] = sig_q12(xi);
            end
            mode = 1'b0;
            eta = nfbm_pkg::LEARN_RESET;
            alpha = nfbm_pkg::MOMENTUM_RESET;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                weights[i] = '0;
                changes[i] = '0;
                loaded[i] = 1'b0;
            end
            acc = '0;
            out_val = '0;
            grad_val = '0;
            elem_idx = 0;
            errors = 0;
        endfunction

        function bit [63:0] decay_q32(bit [31:0] t);
            bit [63:0] frac;
            bit [63:0] term;
            bit [63:0] pos;
            bit [63:0] neg;
            bit [63:0] r;
            frac = 64'(t & 32'hFFF) << 20;
            term = 64'd1 << 32;
            pos = term;
            neg = 0;
            for (int n = 1; n < 16; n++) begin
                term = ((term * frac) >> 32) / 64'(n);
                if (n % 2 == 1) neg += term;
                else pos += term;
            end
            r = pos - neg;
            for (int n = 0; n < int'(t >> 12) && r != 0; n++)
                r = (r * 64'd1580030169) >> 32;
            return r;
        endfunction

        function logic signed [15:0] tanh_q12(logic signed [31:0] x);
            bit [63:0] e;
            bit [63:0] den;
            bit [63:0] r;
            e = decay_q32(2 * (x < 0 ? -x : x));
            den = (64'd1 << 32) + e;
            r = (((64'd1 << 32) - e) * 64'd4096 + den / 2) / den;
            return x < 0 ? -r[15:0] : r[15:0];
        endfunction

        function logic signed [15:0] sig_q12(logic signed [31:0] x);
            bit [63:0] e;
            bit [63:0] den;
            bit [63:0] r;
            e = decay_q32(x < 0 ? -x : x);
            den = (64'd1 << 32) + e;
            r = ((x < 0 ? e : (64'd1 << 32)) * 64'd4096 + den / 2) / den;
            return r[15:0];
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767) return 16'sh7FFF;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function longint slope();
            longint y;
            y = out_val;
            if (mode) return (y * (4096 - y)) >>> 12;
            return 4096 - ((y * y) >>> 12);
        endfunction

        function void write_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                nfbm_pkg::CFG_MODE:     mode = data[0];
                nfbm_pkg::CFG_LEARN:    eta = data;
                nfbm_pkg::CFG_MOMENTUM: alpha = data;
                default: ;
            endcase
        endfunction

        function void push(logic signed [15:0] v, logic [1:0] k);
            t_neuron_result r;
            r.value = v;
            r.kind = k;
            pending = {pending, r};
        endfunction

        function void note_item(logic [2:0] func, logic signed [15:0] v,
                                logic signed [15:0] nw, logic last);
            bit      in_range;
            int      idx;
            longint  x;
            longint  t;
            int      ti;
            logic signed [15:0] c;
            in_range = elem_idx < STORE_DEPTH;
            idx = in_range ? elem_idx : 0;
            case (func)
                nfbm_pkg::FUNC_FORWARD: begin
                    if (in_range) acc = clip32(longint'(acc) + longint'(v) * weights[idx]);
                    if (last) begin
                        x = clip16(longint'(acc) >>> 12);
                        ti = int'(((x + 32768) * ACT_DEPTH) >>> 16);
                        if (ti >= ACT_DEPTH) ti = ACT_DEPTH - 1;
                        out_val = mode ? sig_lut[ti] : tanh_lut[ti];
                        acc = '0;
                        push(out_val, nfbm_pkg::KIND_OUTPUT);
                    end
                end
                nfbm_pkg::FUNC_OUT_GRAD: begin
                    grad_val = clip16(((longint'(v) - out_val) * slope()) >>> 12);
                    push(grad_val, nfbm_pkg::KIND_GRAD);
                end
                nfbm_pkg::FUNC_HID_GRAD: begin
                    acc = clip32(longint'(acc) + longint'(nw) * v);
                    if (last) begin
                        grad_val = clip16((longint'(acc) * slope()) >>> 24);
                        acc = '0;
                        push(grad_val, nfbm_pkg::KIND_GRAD);
                    end
                end
                nfbm_pkg::FUNC_UPDATE: begin
                    if (in_range) begin
                        t = longint'(eta) * v * grad_val
                            + longint'(alpha) * changes[idx] * 4096;
                        c = clip16(t >>> 24);
                        changes[idx] = c;
                        weights[idx] = clip16(longint'(weights[idx]) + c);
                    end
                    if (last) push('0, nfbm_pkg::KIND_UPDATE);
                end
                nfbm_pkg::FUNC_LOAD: begin
                    if (in_range) begin
                        weights[idx] = v;
                        loaded[idx] = 1'b1;
                    end
                    if (last) push('0, nfbm_pkg::KIND_LOAD);
                end
                default: ;
            endcase
            if (last) elem_idx = 0;
            else if (elem_idx < STORE_DEPTH && func != nfbm_pkg::FUNC_OUT_GRAD
                     && func <= nfbm_pkg::FUNC_LOAD)
                elem_idx++;
        endfunction

        function void check_result(logic signed [15:0] v, logic [1:0] k);
            t_neuron_result e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d kind %0d", v, k);
                return;
            end
            e = pending.pop_front();
            if (e.value !== v || e.kind !== k) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value %0d kind %0d, got value %0d kind %0d",
                             e.value, e.kind, v, k);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_func = '0;
    logic signed [15:0] i_value = '0;
    logic signed [15:0] i_next_weight = '0;
    logic               i_last = 1'b0;
    logic               o_result_valid;
    logic signed [15:0] o_result_value;
    logic [1:0]         o_result_kind;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [11:0]        i_cfg_data = '0;

    neuron_scoreboard sb = new();
    int               idle_pct = 0;
    int               quiet_cycles = 0;
    int               item_count = 0;

    neuron_forward_backprop_momentum_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_next_weight  (i_next_weight),
        .i_last         (i_last),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value),
        .o_result_kind  (o_result_kind),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result_value, o_result_kind);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(logic [2:0] func, logic signed [15:0] v,
                        logic signed [15:0] nw, logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_value <= v;
        i_next_weight <= nw;
        i_last <= last;
        do @(posedge i_clk); while (busy);
        sb.note_item(func, v, nw, last);
        item_count++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3, 4: return 16'($signed($urandom_range(16384)) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run();
        int                 len;
        int                 pick;
        logic [2:0]         func;
        logic [2:0]         f;
        pick = $urandom_range(99);
        len = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 1);
        if (pick < 30) func = nfbm_pkg::FUNC_FORWARD;
        else if (pick < 45) func = nfbm_pkg::FUNC_HID_GRAD;
        else if (pick < 65) func = nfbm_pkg::FUNC_UPDATE;
        else if (pick < 80) func = nfbm_pkg::FUNC_LOAD;
        else if (pick < 92) func = nfbm_pkg::FUNC_OUT_GRAD;
        else func = 3'($urandom_range(7, 5));
        if (func == nfbm_pkg::FUNC_OUT_GRAD || func > nfbm_pkg::FUNC_LOAD)
            len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++) begin
            f = func;
            if ((f == nfbm_pkg::FUNC_FORWARD || f == nfbm_pkg::FUNC_UPDATE)
                    && sb.elem_idx < STORE_DEPTH && !sb.loaded[sb.elem_idx])
                f = nfbm_pkg::FUNC_LOAD;
            send(f, pick_value(), pick_value(),
                 (i == len - 1) ? 1'b1 : 1'($urandom_range(39) == 0));
        end
    endtask

    task automatic random_phase(int pct, int count);
        idle_pct = pct;
        item_count = 0;
        while (item_count < count) random_run();
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(nfbm_pkg::CFG_MODE, 12'd0);
        write_reg(nfbm_pkg::CFG_LEARN, 12'd4095);
        write_reg(nfbm_pkg::CFG_MOMENTUM, 12'd4095);

        send(nfbm_pkg::FUNC_LOAD, 16'sh7FFF, '0, 1'b0);
        send(nfbm_pkg::FUNC_LOAD, 16'sh8000, '0, 1'b0);
        send(nfbm_pkg::FUNC_LOAD, 16'sd4096, '0, 1'b0);
        send(nfbm_pkg::FUNC_LOAD, -16'sd4096, '0, 1'b1);
        send(nfbm_pkg::FUNC_FORWARD, 16'sh7FFF, '0, 1'b1);
        send(nfbm_pkg::FUNC_FORWARD, 16'sd4096, '0, 1'b0);
        send(nfbm_pkg::FUNC_FORWARD, 16'sh8000, '0, 1'b0);
        send(nfbm_pkg::FUNC_FORWARD, 16'sd100, '0, 1'b0);
        send(nfbm_pkg::FUNC_FORWARD, 16'sh7FFF, '0, 1'b1);
        send(nfbm_pkg::FUNC_OUT_GRAD, 16'sh7FFF, '0, 1'b0);
        send(nfbm_pkg::FUNC_OUT_GRAD, 16'sh8000, '0, 1'b1);
        send(nfbm_pkg::FUNC_HID_GRAD, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send(nfbm_pkg::FUNC_HID_GRAD, 16'sh8000, 16'sh8000, 1'b0);
        send(nfbm_pkg::FUNC_HID_GRAD, 16'sh8000, 16'sh7FFF, 1'b1);
        send(nfbm_pkg::FUNC_UPDATE, 16'sh7FFF, '0, 1'b0);
        send(nfbm_pkg::FUNC_UPDATE, 16'sh8000, '0, 1'b0);
        send(nfbm_pkg::FUNC_UPDATE, 16'sd0, '0, 1'b1);
        send(3'd5, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send(3'd6, 16'sh8000, 16'sh8000, 1'b0);
        send(3'd7, 16'sd1, 16'sd1, 1'b1);
        send(nfbm_pkg::FUNC_FORWARD, 16'sd2048, '0, 1'b1);
        send(nfbm_pkg::FUNC_OUT_GRAD, 16'sd0, '0, 1'b0);
        drain();

        write_reg(nfbm_pkg::CFG_MODE, 12'd1);
        write_reg(nfbm_pkg::CFG_LEARN, 12'd614);
        write_reg(nfbm_pkg::CFG_MOMENTUM, 12'd2048);
        random_phase(22, 250);

        write_reg(nfbm_pkg::CFG_MODE, 12'd0);
        write_reg(nfbm_pkg::CFG_LEARN, 12'd0);
        write_reg(nfbm_pkg::CFG_MOMENTUM, 12'd0);
        random_phase(88, 250);

        write_reg(nfbm_pkg::CFG_MODE, 12'($urandom_range(1)));
        write_reg(nfbm_pkg::CFG_LEARN, 12'($urandom));
        write_reg(nfbm_pkg::CFG_MOMENTUM, 12'($urandom));
        random_phase(0, 250);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
